// File: design/eps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_pkg
// Shared constants, codes and payload types of the percentile envelope score.
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int REF_DEPTH = 1024;
  localparam int NUM_VARS  = 8;
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int VAR_AW    = $clog2(NUM_VARS);
  localparam int MEM_AW    = VAR_AW + REF_AW;
  localparam int MEM_DEPTH = NUM_VARS * REF_DEPTH;

  // counts up to REF_DEPTH, m = 2*below + equal up to 2*REF_DEPTH
  localparam int CNT_W = REF_AW + 1;
  localparam int M_W   = CNT_W + 1;
  localparam int NUM_W = CNT_W + 16;
  localparam int Q_W   = 17;

  localparam int VAL_W     = 32;
  localparam int REF_CNT_W = 11;
  localparam int VAR_CNT_W = 4;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [Q_W-1:0]       ONE_Q16       = 17'h10000;
  localparam logic [REF_CNT_W-1:0] REF_COUNT_RST = 11'd1024;
  localparam logic [VAR_CNT_W-1:0] VAR_COUNT_RST = 4'd8;

  // register index, taken from paddr[2]
  localparam logic REG_REF_COUNT = 1'b0;
  localparam logic REG_VAR_COUNT = 1'b1;

  localparam logic [1:0] ACT_LOAD_REF = 2'd0;
  localparam logic [1:0] ACT_LOAD_LIM = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_BOTH = 2'd1;
  localparam logic [1:0] TAIL_HIGH = 2'd2;
  localparam logic [1:0] TAIL_LOW  = 2'd3;

  typedef struct packed {
    logic [1:0]              action;
    logic [VAR_AW-1:0]       var_index;
    logic [REF_AW-1:0]       ref_index;
    logic signed [VAL_W-1:0] value;
    logic                    value_missing;
    logic signed [VAL_W-1:0] low_limit;
    logic signed [VAL_W-1:0] high_limit;
    logic [1:0]              tail_mode;
    logic                    last_var;
  } eps_item_t;

  typedef struct packed {
    logic [Q_W-1:0] score;
    logic           score_missing;
  } eps_result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } eps_div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } eps_div_rsp_t;

endpackage

// File: design/eps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module eps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/eps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eps_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  eps_pkg::eps_div_req_t req_i,
  output eps_pkg::eps_div_rsp_t rsp_o
);
  import eps_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W:0]    rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q, num_q[NUM_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits, shift the quotient bit into num
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = CNT_W'(rem_sh - {1'b0, den_q});
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CNT_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q[Q_W-1:0];

endmodule

// File: design/envelope_percentile_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_percentile_score
// Percentile envelope score over sorted reference columns held in one RAM.
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  ------------------
//  item      in         start & !busy                  item_i (eps_item_t)
//  result    out        result_valid_o, one cycle      result_o
//  config    in/out     APB write, psel&penable&pwrite  pwdata / prdata
//
// Loads never raise busy. A query item reads the column of its variable
// one reference row per cycle through the single RAM read port, up to
// n = effective ref_count rows, then the bit-serial divider runs.
// Skipped, missing or out-of-limit values go from the check straight to
// the finish, without walk or divide. No clearing pass after reset.
// The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module envelope_percentile_score (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  eps_pkg::eps_item_t            item_i,
  output logic                          result_valid_o,
  output eps_pkg::eps_result_t          result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eps_pkg::APB_AW-1:0]    paddr,
  input  logic [eps_pkg::APB_DW-1:0]    pwdata,
  output logic [eps_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import eps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [REF_CNT_W-1:0] ref_count_q;
  logic [VAR_CNT_W-1:0] var_count_q;
  logic [CNT_W-1:0]     n_eff;
  logic [VAR_CNT_W-1:0] var_eff;

  logic [Q_W-1:0] run_min_q, run_min_d;
  logic           pt_miss_q, pt_miss_d;
  logic           last_q, last_d;
  logic           cmp_vld_q, cmp_vld_d;

  logic [VAR_AW-1:0]       var_q, var_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    miss_q, miss_d;
  logic [CNT_W-1:0]        below_q, below_d;
  logic [CNT_W-1:0]        equal_q, equal_d;
  logic [CNT_W-1:0]        rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]        cmp_idx_q, cmp_idx_d;

  logic signed [VAL_W-1:0] lo_store_q [NUM_VARS];
  logic signed [VAL_W-1:0] hi_store_q [NUM_VARS];
  logic [1:0]              tail_store_q [NUM_VARS];

  logic                    accept;
  logic                    ram_we;
  logic                    ram_re;
  logic [VAL_W-1:0]        ram_rdata;
  logic signed [VAL_W-1:0] ref_val;
  logic                    walk_stop;
  logic                    cfg_wr;

  logic [M_W-1:0] m_val;
  logic [M_W-1:0] n_val;
  logic [M_W-1:0] mirror;
  logic [1:0]     tail;

  eps_div_req_t div_req;
  eps_div_rsp_t div_rsp;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign ram_we = accept && (item_i.action == ACT_LOAD_REF);
  assign ref_val = $signed(ram_rdata);

  always_comb begin
    if (ref_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(ref_count_q) > CNT_W'(REF_DEPTH)) begin
      n_eff = CNT_W'(REF_DEPTH);
    end else begin
      n_eff = CNT_W'(ref_count_q);
    end
    if (var_count_q == '0) begin
      var_eff = VAR_CNT_W'(1);
    end else if (var_count_q > VAR_CNT_W'(NUM_VARS)) begin
      var_eff = VAR_CNT_W'(NUM_VARS);
    end else begin
      var_eff = var_count_q;
    end
  end

  eps_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MEM_DEPTH)
  ) u_ref_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i({item_i.var_index, item_i.ref_index}),
    .wdata_i(item_i.value),
    .re_i   (ram_re),
    .raddr_i({var_q, rd_idx_q[REF_AW-1:0]}),
    .rdata_o(ram_rdata)
  );

  eps_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // fold inputs: m = 2*below + equal, mirror = 2n - m; untailed z = m / 2n
  assign m_val  = M_W'({below_q, 1'b0}) + M_W'(equal_q);
  assign n_val  = M_W'(n_eff);
  assign mirror = M_W'({n_eff, 1'b0}) - m_val;
  assign tail   = tail_store_q[var_q];

  always_comb begin
    state_d   = state_q;
    run_min_d = run_min_q;
    pt_miss_d = pt_miss_q;
    last_d    = last_q;
    cmp_vld_d = cmp_vld_q;
    var_d     = var_q;
    value_d   = value_q;
    miss_d    = miss_q;
    below_d   = below_q;
    equal_d   = equal_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    ram_re    = 1'b0;
    walk_stop = 1'b0;
    div_req   = '0;
    result_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept && item_i.action == ACT_QUERY) begin
          var_d   = item_i.var_index;
          value_d = item_i.value;
          miss_d  = item_i.value_missing;
          last_d  = item_i.last_var;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pt_miss_q || VAR_CNT_W'(var_q) >= var_eff) begin
          state_d = S_FIN;
        end else if (miss_q) begin
          pt_miss_d = 1'b1;
          state_d   = S_FIN;
        end else if (value_q < lo_store_q[var_q] || value_q > hi_store_q[var_q]) begin
          run_min_d = '0;
          state_d   = S_FIN;
        end else begin
          below_d  = '0;
          equal_d  = '0;
          rd_idx_d = '0;
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        // issue the next row while comparing the one read last cycle
        ram_re    = 1'b1;
        rd_idx_d  = rd_idx_q + 1'b1;
        cmp_idx_d = rd_idx_q;
        cmp_vld_d = 1'b1;
        if (cmp_vld_q) begin
          if (value_q > ref_val) begin
            below_d = below_q + 1'b1;
          end else if (value_q == ref_val) begin
            equal_d = equal_q + 1'b1;
          end else begin
            walk_stop = 1'b1;
          end
          if (cmp_idx_q == n_eff - 1'b1) begin
            walk_stop = 1'b1;
          end
        end
        if (walk_stop) begin
          cmp_vld_d = 1'b0;
          state_d   = S_FOLD;
        end
      end
      S_FOLD: begin
        div_req.den = n_eff;
        case (tail)
          TAIL_BOTH: begin
            div_req.start = 1'b1;
            if (m_val > n_val) begin
              div_req.num = {mirror[CNT_W-1:0], 16'b0};
            end else begin
              div_req.num = {m_val[CNT_W-1:0], 16'b0};
            end
          end
          TAIL_HIGH: begin
            // below the median saturates at one, never lowering the minimum
            div_req.start = (m_val >= n_val);
            div_req.num   = {mirror[CNT_W-1:0], 16'b0};
          end
          TAIL_LOW: begin
            div_req.start = (m_val <= n_val);
            div_req.num   = {m_val[CNT_W-1:0], 16'b0};
          end
          default: begin
            div_req.start = 1'b1;
            div_req.num   = {m_val, 15'b0};
          end
        endcase
        state_d = div_req.start ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot < run_min_q) begin
            run_min_d = div_rsp.quot;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (last_q) begin
          result_valid_o = 1'b1;
          run_min_d      = ONE_Q16;
          pt_miss_d      = 1'b0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign result_o.score         = pt_miss_q ? '0 : run_min_q;
  assign result_o.score_missing = pt_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      run_min_q <= ONE_Q16;
      pt_miss_q <= 1'b0;
      last_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_min_q <= run_min_d;
      pt_miss_q <= pt_miss_d;
      last_q    <= last_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    var_q     <= var_d;
    value_q   <= value_d;
    miss_q    <= miss_d;
    below_q   <= below_d;
    equal_q   <= equal_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    if (accept && item_i.action == ACT_LOAD_LIM) begin
      lo_store_q[item_i.var_index]   <= item_i.low_limit;
      hi_store_q[item_i.var_index]   <= item_i.high_limit;
      tail_store_q[item_i.var_index] <= item_i.tail_mode;
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q <= REF_COUNT_RST;
      var_count_q <= VAR_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VAR_COUNT) begin
        var_count_q <= pwdata[VAR_CNT_W-1:0];
      end else begin
        ref_count_q <= pwdata[REF_CNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_REF_COUNT) ? APB_DW'(ref_count_q) : APB_DW'(var_count_q);

endmodule

// File: bench/tb_envelope_percentile_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_envelope_percentile_score
// Self-checking bench for the percentile envelope score block. Reference
// columns and limits are loaded through the item port, query points are
// scored by an in-bench model of the column walk and tail fold, and every
// result strobe is compared field by field with the oldest pending score.
// ----------------------------------------------------------------------------
module tb_envelope_percentile_score;
  import eps_pkg::*;

  localparam logic [1:0]        ACT_UNUSED     = 2'd3;
  localparam logic signed [31:0] VAL_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX       = 32'sh7FFF_FFFF;
  localparam int                SETTLE_CYCLES  = REF_DEPTH + NUM_W + 64;
  localparam int                RANDOM_QUERIES = 580;
  localparam longint            TIMEOUT_NS     = 64'd50_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  eps_item_t             item_i;
  logic                  result_valid_o;
  eps_result_t           result_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  envelope_percentile_score DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Envelope state mirrored by the bench
  logic signed [31:0] col_ref [NUM_VARS][REF_DEPTH];
  logic signed [31:0] lim_lo  [NUM_VARS];
  logic signed [31:0] lim_hi  [NUM_VARS];
  logic [1:0]         tail_sel [NUM_VARS];
  logic [Q_W-1:0]     run_min;
  logic               run_missing;
  int unsigned        cfg_ref_count;
  int unsigned        cfg_var_count;

  eps_result_t        pending_scores [$];
  eps_result_t        want_score;

  int mismatches;
  int items_sent;
  int queries_sent;
  int points_scored;
  int results_checked;
  int settings_run;
  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d scores still pending", pending_scores.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want_v);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want_v);
    mismatches++;
  endtask

  // Compare every result strobe with the oldest pending score
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_checked++;
      if (pending_scores.size() == 0) begin
        report_mismatch("unexpected result, score", result_o.score, -1);
      end else begin
        want_score = pending_scores.pop_front();
        if (result_o.score !== want_score.score)
          report_mismatch("score", result_o.score, want_score.score);
        if (result_o.score_missing !== want_score.score_missing)
          report_mismatch("score_missing", result_o.score_missing, want_score.score_missing);
      end
    end
  end

  function automatic int unsigned eff_ref_count();
    if (cfg_ref_count == 0) return 1;
    if (cfg_ref_count > REF_DEPTH) return REF_DEPTH;
    return cfg_ref_count;
  endfunction

  function automatic int unsigned eff_var_count();
    if (cfg_var_count == 0) return 1;
    if (cfg_var_count > NUM_VARS) return NUM_VARS;
    return cfg_var_count;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > longint'(VAL_MAX)) return VAL_MAX;
    if (x < longint'(VAL_MIN)) return VAL_MIN;
    return x[31:0];
  endfunction

  // Walk the column up to the first larger entry, then fold by tail mode
  function automatic logic [Q_W-1:0] percentile_q16(input int unsigned v,
                                                     input logic signed [31:0] x);
    int unsigned      n;
    longint unsigned  below, equal, m, nn, q;
    n = eff_ref_count();
    below = 0;
    equal = 0;
    for (int j = 0; j < n; j++) begin
      if (x > col_ref[v][j]) below++;
      else if (x == col_ref[v][j]) equal++;
      else break;
    end
    m = 2 * below + equal;
    nn = n;
    case (tail_sel[v])
      TAIL_BOTH: q = (m > nn) ? ((2 * nn - m) * 65536) / nn : (m * 65536) / nn;
      TAIL_HIGH: q = (m < nn) ? 65536 : ((2 * nn - m) * 65536) / nn;
      TAIL_LOW:  q = (m > nn) ? 65536 : (m * 65536) / nn;
      default:   q = (m * 32768) / nn;
    endcase
    return q[Q_W-1:0];
  endfunction

  // Advance the mirrored state by one accepted item; queue the score on a query with last_var
  task automatic score_item(input eps_item_t it);
    logic [Q_W-1:0] z;
    eps_result_t    r;
    if (it.action == ACT_LOAD_REF) begin
      col_ref[it.var_index][it.ref_index] = it.value;
    end else if (it.action == ACT_LOAD_LIM) begin
      lim_lo[it.var_index]   = it.low_limit;
      lim_hi[it.var_index]   = it.high_limit;
      tail_sel[it.var_index] = it.tail_mode;
    end else if (it.action == ACT_QUERY) begin
      if (!run_missing && it.var_index < eff_var_count()) begin
        if (it.value_missing) begin
          run_missing = 1'b1;
        end else if (it.value < lim_lo[it.var_index] || it.value > lim_hi[it.var_index]) begin
          run_min = '0;
        end else begin
          z = percentile_q16(it.var_index, it.value);
          if (z < run_min) run_min = z;
        end
      end
      if (it.last_var) begin
        r.score         = run_missing ? '0 : run_min;
        r.score_missing = run_missing;
        pending_scores.push_back(r);
        run_min     = ONE_Q16;
        run_missing = 1'b0;
        points_scored++;
      end
    end
  endtask

  // Bursts of back-to-back items, usually separated by random gaps
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input eps_item_t it);
    pace_sender();
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    score_item(it);
  endtask

  function automatic eps_item_t junk_item();
    eps_item_t it;
    it.action        = $urandom_range(0, 3);
    it.var_index     = $urandom_range(0, NUM_VARS - 1);
    it.ref_index     = $urandom_range(0, REF_DEPTH - 1);
    it.value         = $urandom;
    it.value_missing = $urandom_range(0, 1);
    it.low_limit     = $urandom;
    it.high_limit    = $urandom;
    it.tail_mode     = $urandom_range(0, 3);
    it.last_var      = $urandom_range(0, 1);
    return it;
  endfunction

  task automatic send_load_ref(input int v, input int row, input logic signed [31:0] val);
    eps_item_t it;
    it = junk_item();
    it.action    = ACT_LOAD_REF;
    it.var_index = v;
    it.ref_index = row;
    it.value     = val;
    send_item(it);
  endtask

  task automatic send_load_lim(input int v, input logic signed [31:0] lo,
                               input logic signed [31:0] hi, input logic [1:0] tail);
    eps_item_t it;
    it = junk_item();
    it.action     = ACT_LOAD_LIM;
    it.var_index  = v;
    it.low_limit  = lo;
    it.high_limit = hi;
    it.tail_mode  = tail;
    send_item(it);
  endtask

  task automatic send_query(input int v, input logic signed [31:0] val,
                            input logic miss, input logic last);
    eps_item_t it;
    it = junk_item();
    it.action        = ACT_QUERY;
    it.var_index     = v;
    it.value         = val;
    it.value_missing = miss;
    it.last_var      = last;
    queries_sent++;
    send_item(it);
  endtask

  task automatic send_unused(input logic last);
    eps_item_t it;
    it = junk_item();
    it.action   = ACT_UNUSED;
    it.last_var = last;
    send_item(it);
  endtask

  task automatic apb_write(input logic reg_sel, input int unsigned val);
    logic [APB_DW-1:0] wdata;
    // junk in the unused upper bits
    wdata = $urandom;
    if (reg_sel == REG_REF_COUNT) wdata[REF_CNT_W-1:0] = val;
    else wdata[VAR_CNT_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_sel == REG_REF_COUNT) cfg_ref_count = wdata[REF_CNT_W-1:0];
    else cfg_var_count = wdata[VAR_CNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic reg_sel);
    logic [APB_DW-1:0] got, want_v;
    want_v = (reg_sel == REG_REF_COUNT) ? cfg_ref_count : cfg_var_count;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want_v) report_mismatch("register read", got, want_v);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_scores.size() != 0);
  endtask

  // Idle long enough for a query item without a result to finish
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Ascending columns for every variable in use, with ties and saturation
  task automatic fill_columns();
    int unsigned n;
    int          style;
    longint      acc;
    n = eff_ref_count();
    for (int v = 0; v < eff_var_count(); v++) begin
      style = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) acc = VAL_MIN;
      else if (style == 2) acc = $signed($urandom);
      else acc = $signed($urandom_range(0, 4000)) - 2000;
      for (int r = 0; r < n; r++) begin
        send_load_ref(v, r, clamp32(acc));
        case (style)
          0: acc = acc + $urandom_range(0, 2);
          1: acc = acc + $urandom_range(0, 1000);
          default: acc = acc + $urandom_range(0, 1 << 24);
        endcase
      end
    end
  endtask

  task automatic load_limit_for(input int v);
    int unsigned n;
    int          style, a, b;
    longint      lo, hi;
    n = eff_ref_count();
    style = $urandom_range(0, 5);
    if (v < eff_var_count() && style <= 3) begin
      lo = col_ref[v][0];
      lo = lo - $urandom_range(0, 50);
      hi = col_ref[v][n - 1];
      hi = hi + $urandom_range(0, 50);
    end else if (v < eff_var_count() && style == 4) begin
      a  = $urandom_range(0, n - 1);
      b  = $urandom_range(a, n - 1);
      lo = col_ref[v][a];
      hi = col_ref[v][b];
    end else begin
      // may come out inverted
      lo = $signed($urandom);
      hi = $signed($urandom);
    end
    send_load_lim(v, clamp32(lo), clamp32(hi), $urandom_range(0, 3));
  endtask

  function automatic logic signed [31:0] pick_value(input int v);
    logic signed [31:0] base;
    longint             t;
    if (v >= eff_var_count()) return $urandom;
    base = col_ref[v][$urandom_range(0, eff_ref_count() - 1)];
    t = base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return base;
      5: return clamp32(t + 1);
      6: return clamp32(t - 1);
      7: return lim_lo[v];
      8: return lim_hi[v];
      default: begin
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        return $urandom;
      end
    endcase
  endfunction

  task automatic random_load();
    if ($urandom_range(0, 1) != 0)
      send_load_ref($urandom_range(0, NUM_VARS - 1), $urandom_range(0, eff_ref_count() - 1),
                    $urandom);
    else
      load_limit_for($urandom_range(0, NUM_VARS - 1));
  endtask

  task automatic setup_phase(input int unsigned ref_cnt, input int unsigned var_cnt);
    settle_block();
    apb_write(REG_REF_COUNT, ref_cnt);
    apb_write(REG_VAR_COUNT, var_cnt);
    check_reg(REG_REF_COUNT);
    check_reg(REG_VAR_COUNT);
    fill_columns();
    for (int v = 0; v < NUM_VARS; v++) load_limit_for(v);
    settings_run++;
  endtask

  // Mostly complete points in shuffled order; some noise, loads and unused items
  task automatic run_points(input int count);
    int kind, k, nv, j, tmp, v;
    int order [NUM_VARS];
    for (int p = 0; p < count; p++) begin
      kind = $urandom_range(0, 9);
      k = eff_var_count();
      if (kind == 9) repeat ($urandom_range(1, 2)) send_unused($urandom_range(0, 1));
      if (kind == 7) begin
        nv = $urandom_range(1, 4);
        for (int i = 0; i < nv; i++) begin
          v = $urandom_range(0, NUM_VARS - 1);
          send_query(v, pick_value(v), $urandom_range(0, 15) == 0, i == nv - 1);
        end
      end else begin
        for (int i = 0; i < k; i++) order[i] = i;
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < k; i++) begin
          if (kind == 8 && i == k / 2) repeat ($urandom_range(1, 3)) random_load();
          send_query(order[i], pick_value(order[i]), $urandom_range(0, 19) == 0, i == k - 1);
        end
      end
    end
  endtask

  task automatic test_register_reset();
    check_reg(REG_REF_COUNT);
    check_reg(REG_VAR_COUNT);
  endtask

  // Tiny columns: ties, extremes, limits, every tail, missing, skipped variables
  task automatic test_directed_cases();
    apb_write(REG_REF_COUNT, 4);
    apb_write(REG_VAR_COUNT, 3);
    send_load_ref(0, 0, VAL_MIN); send_load_ref(0, 1, -5); send_load_ref(0, 2, -5);
    send_load_ref(0, 3, VAL_MAX);
    send_load_ref(1, 0, 10); send_load_ref(1, 1, 20); send_load_ref(1, 2, 30);
    send_load_ref(1, 3, 40);
    // out of order column: the walk stops at the first larger entry
    send_load_ref(2, 0, 50); send_load_ref(2, 1, 40); send_load_ref(2, 2, 60);
    send_load_ref(2, 3, 70);
    send_load_lim(0, VAL_MIN, VAL_MAX, TAIL_NONE);
    send_load_lim(1, 10, 40, TAIL_BOTH);
    send_load_lim(2, VAL_MIN, VAL_MAX, TAIL_HIGH);

    send_query(0, -5, 1'b0, 1'b0); send_query(1, 25, 1'b0, 1'b0);
    send_query(2, 55, 1'b0, 1'b1);
    send_query(0, VAL_MIN, 1'b0, 1'b0); send_query(1, 10, 1'b0, 1'b0);
    send_query(2, VAL_MAX, 1'b0, 1'b1);
    send_query(2, VAL_MIN, 1'b0, 1'b0); send_query(1, 40, 1'b0, 1'b0);
    send_query(0, VAL_MAX, 1'b0, 1'b1);
    // variable 1 below its low limit
    send_query(0, 0, 1'b0, 1'b0); send_query(1, 9, 1'b0, 1'b0);
    send_query(2, 45, 1'b0, 1'b1);
    // missing first, then an out-of-limit value that must not matter
    send_query(0, 3, 1'b1, 1'b0); send_query(1, 41, 1'b0, 1'b0);
    send_query(2, 60, 1'b0, 1'b1);
    // skipped variable, flagged missing, still ends the point
    send_query(5, 7, 1'b1, 1'b1);
    send_unused(1'b1);
    send_query(1, 30, 1'b0, 1'b0); send_query(0, -6, 1'b0, 1'b0);
    send_query(2, 70, 1'b0, 1'b1);

    send_load_lim(0, 100, -100, TAIL_BOTH);
    send_load_lim(1, 10, 40, TAIL_LOW);
    send_load_lim(2, VAL_MIN, VAL_MAX, TAIL_BOTH);
    send_query(0, 0, 1'b0, 1'b0); send_query(1, 20, 1'b0, 1'b0);
    send_query(2, 40, 1'b0, 1'b1);
    send_load_lim(0, VAL_MIN, VAL_MAX, TAIL_LOW);
    send_query(1, 35, 1'b0, 1'b0); send_query(0, -5, 1'b0, 1'b0);
    send_query(2, 50, 1'b0, 1'b0); send_query(7, 1, 1'b0, 1'b1);
    settings_run++;
  endtask

  // Register extremes: zero and over-range counts, single row, full depth
  task automatic test_count_extremes();
    setup_phase(0, 0);
    run_points(6);
    setup_phase(2047, 15);
    run_points(3);
    setup_phase(1, 8);
    run_points(8);
    setup_phase(1024, 1);
    run_points(6);
  endtask

  task automatic test_random_points();
    int          base, pts;
    int unsigned rc, vc;
    base = queries_sent;
    while (queries_sent - base < RANDOM_QUERIES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: rc = $urandom_range(1, 32);
        7, 8: rc = $urandom_range(33, 160);
        default: rc = $urandom_range(161, 300);
      endcase
      vc = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 15);
      setup_phase(rc, vc);
      pts = $urandom_range(8, 24);
      run_points(pts / 2);
      // hold off until every pending score is out
      drain_results();
      run_points(pts - pts / 2);
    end
  endtask

  initial begin
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cfg_ref_count = REF_COUNT_RST;
    cfg_var_count = VAR_COUNT_RST;
    run_min       = ONE_Q16;
    run_missing   = 1'b0;
    burst_left    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_cases();
    test_count_extremes();
    test_random_points();

    settle_block();
    if (pending_scores.size() != 0)
      report_mismatch("scores never delivered", 0, pending_scores.size());
    $display("Run covered %0d items, %0d query values, %0d register settings.",
             items_sent, queries_sent, settings_run);
    $display("Scored %0d points, checked %0d results, %0d errors.",
             points_scored, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: envelope_percentile_score.f
design/eps_pkg.sv
design/eps_ram.sv
design/eps_div.sv
design/envelope_percentile_score.sv
bench/tb_envelope_percentile_score.sv
